// File: sv/bkvf_pkg.sv
// Shared types and constants of the bang-delimited key/value framer.
package bkvf_pkg;

  // Default buffer depth in bytes
  localparam int DEPTH_DEFAULT = 64;

  // Frame delimiter, key/value separator and shortest legal frame
  localparam logic [7:0] BANG_CHAR     = 8'h21;
  localparam logic [7:0] EQ_CHAR       = 8'h3D;
  localparam int         MIN_FRAME_LEN = 5;

  // Field widths of the stream items
  localparam int CMD_W    = 2;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 3;
  localparam int LENGTH_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_BYTE    = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED    = 3'd0,
    ST_STORED     = 3'd1,
    ST_ACCEPTED   = 3'd2,
    ST_FORMAT_ERR = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_REFUSED    = 3'd5,
    ST_RELEASED   = 3'd6,
    ST_READ       = 3'd7
  } status_t;

  // Result of one transfer, handed from the controller to the output register
  typedef struct packed {
    status_t             status;
    logic                frame_ready;
    logic [LENGTH_W-1:0] frame_length;
    logic                rd_valid;
  } res_t;

endpackage

// File: sv/bkvf_store.sv
// Frame byte buffer with one write port and one registered read port.
module bkvf_store #(
  parameter int DEPTH = bkvf_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [CW-1:0]             wr_addr,
  input  logic [bkvf_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [CW-1:0]             rd_addr,
  output logic [bkvf_pkg::BYTE_W-1:0] rd_data
);
  import bkvf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  // Write the incoming byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read word on each accepted transfer
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/bkvf_ctrl.sv
// Frame tracking state, incremental format check and status decode.
module bkvf_ctrl #(
  parameter int DEPTH = bkvf_pkg::DEPTH_DEFAULT,
  parameter int CW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [bkvf_pkg::CMD_W-1:0]   command,
  input  logic [bkvf_pkg::BYTE_W-1:0]  rx_byte,
  input  logic [bkvf_pkg::INDEX_W-1:0] read_index,
  output logic                         wr_en,
  output logic [CW-1:0]                wr_addr,
  output logic [CW-1:0]                rd_addr,
  output bkvf_pkg::res_t               res
);
  import bkvf_pkg::*;

  localparam int            CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] LAST = CW'(DEPTH - 1);
  localparam logic [CW-1:0] MINL = CW'(MIN_FRAME_LEN);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  logic          in_frame, in_frame_next;
  logic          held, held_next;
  logic [CW-1:0] stored_count, stored_count_next;
  logic [1:0]    equals_seen, equals_seen_next;
  logic [CW-1:0] equals_place, equals_place_next;

  logic          start;
  logic          open;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt1;
  logic [1:0]    eqs;
  logic [CW-1:0] eqp;
  logic          good;
  cmd_t          cmd;

  assign cmd = cmd_t'(command);

  // Decode one transfer against the current frame state
  always_comb begin
    in_frame_next     = in_frame;
    held_next         = held;
    stored_count_next = stored_count;
    equals_seen_next  = equals_seen;
    equals_place_next = equals_place;
    wr_en             = 1'b0;
    res.status        = ST_IGNORED;
    res.rd_valid      = 1'b0;

    // An opening bang restarts the count and the separator tracking
    start = (rx_byte == BANG_CHAR) && !in_frame;
    open  = in_frame || start;
    cnt   = start ? '0 : stored_count;
    eqs   = start ? 2'd0 : equals_seen;
    eqp   = start ? '0 : equals_place;
    if (rx_byte == EQ_CHAR) begin
      eqs = (eqs == 2'd2) ? 2'd2 : eqs + 2'd1;
      eqp = cnt;
    end
    cnt1 = cnt + ONE;
    good = (cnt1 >= MINL) && (eqs == 2'd1) && (eqp != ONE) && (eqp != cnt1 - TWO);

    case (cmd)
      CMD_BYTE: begin
        if (held) begin
          res.status = ST_REFUSED;
        end else if (open) begin
          if (cnt < LAST) begin
            wr_en             = 1'b1;
            in_frame_next     = 1'b1;
            stored_count_next = cnt1;
            equals_seen_next  = eqs;
            equals_place_next = eqp;
            res.status        = ST_STORED;
            // Close on a bang once more than the opener is stored
            if ((rx_byte == BANG_CHAR) && (cnt1 > ONE)) begin
              in_frame_next = 1'b0;
              if (good) begin
                held_next  = 1'b1;
                res.status = ST_ACCEPTED;
              end else begin
                stored_count_next = '0;
                res.status        = ST_FORMAT_ERR;
              end
            end
          end else begin
            // Buffer full: drop the frame and lose the byte
            in_frame_next     = 1'b0;
            stored_count_next = '0;
            equals_seen_next  = eqs;
            equals_place_next = eqp;
            res.status        = ST_OVERFLOW;
          end
        end
      end
      CMD_RELEASE: begin
        if (held) begin
          held_next         = 1'b0;
          stored_count_next = '0;
        end
        res.status = ST_RELEASED;
      end
      CMD_READ: begin
        res.rd_valid = CMPW'(read_index) < CMPW'(stored_count);
        res.status   = ST_READ;
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase

    res.frame_ready  = held_next;
    res.frame_length = LENGTH_W'(stored_count_next);
  end

  assign wr_addr = cnt;
  assign rd_addr = CW'(read_index);

  // Advance the frame state on each accepted transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      held         <= 1'b0;
      stored_count <= '0;
      equals_seen  <= 2'd0;
      equals_place <= '0;
    end else if (accept) begin
      in_frame     <= in_frame_next;
      held         <= held_next;
      stored_count <= stored_count_next;
      equals_seen  <= equals_seen_next;
      equals_place <= equals_place_next;
    end
  end

  // A held frame is closed and long enough
  a_held_closed: assert property (@(posedge clk) disable iff (rst)
    held |-> !in_frame && (stored_count >= MINL))
    else $error("held frame is still open or too short");

  // The separator count saturates at two
  a_eq_sat: assert property (@(posedge clk) disable iff (rst)
    equals_seen != 2'd3)
    else $error("separator count beyond saturation");

  // The count never exceeds the buffer's last slot
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= LAST)
    else $error("stored count beyond buffer depth");

  // A byte is written only while a frame is open and nothing is held
  a_write_ok: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en) |-> !held && (cnt < LAST))
    else $error("buffer write while held or full");

endmodule

// File: sv/bang_delimited_key_value_framer_core.sv
// Top level of the bang-delimited key/value framer: stream ports and output register.
//
// Takes one command per transfer (received byte, release, or read) and returns
// exactly one result per transfer. One transfer is accepted every clock cycle unless
// a waiting result is stalled; each result is valid in the output register on the
// following cycle, set by the registered read port of the frame buffer. Input is
// taken while a result waits as long as the downstream side takes that result in
// the same cycle. A good frame is held, and further bytes are refused, until a
// release command. The buffer needs no clearing pass after reset: only bytes of
// the current frame are ever read back.
module bang_delimited_key_value_framer_core #(
  parameter int DEPTH = bkvf_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,  // command[1:0]
  input  logic [15:0] s_tdata,  // rx_byte[7:0], read_index[13:8], zero[15:14]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // status[2:0], frame_ready[3], frame_length[9:4],
                                // read_data[17:10], zero[23:18]
);
  import bkvf_pkg::*;

  localparam int CW = $clog2(DEPTH);

  logic              accept;
  logic              wr_en;
  logic [CW-1:0]     wr_addr;
  logic [CW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] rx_byte;
  res_t              res;
  res_t              res_q;
  logic              out_valid;

  assign rx_byte  = s_tdata[7:0];
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  bkvf_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (s_tuser),
    .rx_byte    (rx_byte),
    .read_index (s_tdata[13:8]),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .res        (res)
  );

  bkvf_store #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture the result fields of each accepted transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0,
                     res_q.rd_valid ? rd_data : 8'd0,
                     res_q.frame_length,
                     res_q.frame_ready,
                     res_q.status};

endmodule

// File: verif/framer_checker.sv
`timescale 1ns / 100ps
// Checker for the framer: predicts every result from the accepted commands and compares it.
module framer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [1:0]  s_tuser,  // command[1:0]
  input  logic [15:0] s_tdata,  // rx_byte[7:0], read_index[13:8], zero[15:14]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,  // status[2:0], frame_ready[3], frame_length[9:4],
                                // read_data[17:10], zero[23:18]
  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          frames_accepted,
  output int          frames_rejected,
  output int          frames_dropped
);
  import bkvf_pkg::*;

  localparam int BUF_DEPTH = DEPTH_DEFAULT;

  typedef struct packed {
    status_t             status;
    logic                frame_ready;
    logic [LENGTH_W-1:0] frame_length;
    logic [BYTE_W-1:0]   read_data;
  } framer_result_t;

  // Results still owed by the block, oldest first
  framer_result_t awaited_results[$];

  // Shadow of the framer state
  logic [BYTE_W-1:0] frame_copy [BUF_DEPTH];
  logic              in_frame;
  logic              held;
  int unsigned       stored;
  int unsigned       equals_seen;
  int unsigned       equals_at;
  int                mismatch_total = 0;

  // Received byte: open, extend, close or drop the frame being assembled
  function automatic status_t take_rx_byte(input logic [BYTE_W-1:0] rx);
    status_t st;
    if (held) return ST_REFUSED;
    if (rx == BANG_CHAR && !in_frame) begin
      stored      = 0;
      equals_seen = 0;
      equals_at   = 0;
      in_frame    = 1'b1;
    end
    if (!in_frame) return ST_IGNORED;
    // No room left: the whole frame goes, and so does this byte
    if (stored >= BUF_DEPTH - 1) begin
      in_frame = 1'b0;
      stored   = 0;
      frames_dropped++;
      return ST_OVERFLOW;
    end
    frame_copy[stored] = rx;
    if (rx == EQ_CHAR) begin
      if (equals_seen < 2) equals_seen++;
      equals_at = stored;
    end
    stored++;
    st = ST_STORED;
    // Closing delimiter: one '=' with text on both sides, at least five bytes
    if (rx == BANG_CHAR && stored > 1) begin
      in_frame = 1'b0;
      if (stored >= MIN_FRAME_LEN && equals_seen == 1 && equals_at != 1 &&
          equals_at != stored - 2) begin
        held = 1'b1;
        st   = ST_ACCEPTED;
        frames_accepted++;
      end else begin
        stored = 0;
        st     = ST_FORMAT_ERR;
        frames_rejected++;
      end
    end
    return st;
  endfunction

  // Work out the result of one accepted command and advance the shadow state
  function automatic framer_result_t predict_transfer(input logic [1:0] user,
                                                      input logic [15:0] item);
    logic [CMD_W-1:0]   command;
    logic [BYTE_W-1:0]  rx;
    logic [INDEX_W-1:0] idx;
    framer_result_t     r;
    command = user;
    rx      = item[7:0];
    idx     = item[13:8];
    r       = '0;
    case (command)
      CMD_BYTE: begin
        r.status = take_rx_byte(rx);
      end
      CMD_RELEASE: begin
        if (held) begin
          held   = 1'b0;
          stored = 0;
        end
        r.status = ST_RELEASED;
      end
      CMD_READ: begin
        if (idx < stored) r.read_data = frame_copy[idx];
        r.status = ST_READ;
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase
    r.frame_ready  = held;
    r.frame_length = LENGTH_W'(stored);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_total++;
    end
  endtask

  // Compare each result transfer first, then record the command taken at the same edge
  always @(posedge clk) begin : monitor
    framer_result_t want;
    framer_result_t got;
    if (rst) begin
      in_frame    = 1'b0;
      held        = 1'b0;
      stored      = 0;
      equals_seen = 0;
      equals_at   = 0;
      foreach (frame_copy[i]) frame_copy[i] = '0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status       = status_t'(m_tdata[2:0]);
        got.frame_ready  = m_tdata[3];
        got.frame_length = m_tdata[9:4];
        got.read_data    = m_tdata[17:10];
        if (awaited_results.size() == 0) begin
          $error("result with no command pending: status %0d, frame_length %0d",
                 got.status, got.frame_length);
          mismatch_total++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("frame_ready", want.frame_ready, got.frame_ready);
          check_field("frame_length", want.frame_length, got.frame_length);
          check_field("read_data", want.read_data, got.read_data);
          results_checked++;
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(predict_transfer(s_tuser, s_tdata));
    end
    outstanding <= awaited_results.size();
    mismatches  <= mismatch_total;
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Testbench top for the framer: clock, reset, command stimulus, output backpressure, verdict.
module testbench;
  import bkvf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS     = 400;
  localparam int ITEM_TARGET     = 1650;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum int {
    FR_GOOD, FR_NO_EQ, FR_MULTI_EQ, FR_EQ_FIRST, FR_EQ_LAST, FR_SHORT, FR_OVERFLOW, FR_LONGEST
  } frame_kind_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser  = '0;  // command[1:0]
  logic [15:0] s_tdata  = '0;  // rx_byte[7:0], read_index[13:8], zero[15:14]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // status[2:0], frame_ready[3], frame_length[9:4],
                               // read_data[17:10], zero[23:18]

  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int quiet_cycles  = 0;

  int mismatches;
  int outstanding;
  int results_checked;
  int frames_accepted;
  int frames_rejected;
  int frames_dropped;

  always #6 clk = ~clk;

  bang_delimited_key_value_framer_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  framer_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tuser         (s_tuser),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .frames_accepted (frames_accepted),
    .frames_rejected (frames_rejected),
    .frames_dropped  (frames_dropped)
  );

  // Result side: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      m_tready     <= 1'b0;
      hold_left    <= HOLD_OFF_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one command after a random idle gap and hold it until the transfer
  task automatic send_item(input logic [CMD_W-1:0] command, input logic [BYTE_W-1:0] rx,
                           input logic [INDEX_W-1:0] idx);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= command;
    s_tdata  <= {2'b00, idx, rx};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Frame text: any byte but the delimiter and the separator
  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == BANG_CHAR || b == EQ_CHAR);
    return b;
  endfunction

  // Send frame bytes, now and then slipping another command in between
  task automatic send_bytes(input logic [BYTE_W-1:0] q[$]);
    foreach (q[i]) begin
      if ($urandom_range(19) == 0)
        send_item(CMD_W'($urandom_range(1, 3)), BYTE_W'($urandom), INDEX_W'($urandom));
      send_item(CMD_BYTE, q[i], INDEX_W'($urandom));
    end
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [BYTE_W-1:0] q[$];
    int klen;
    int vlen;
    klen = $urandom_range(1, 6);
    vlen = $urandom_range(1, 6);
    q.push_back(BANG_CHAR);
    case (kind)
      FR_GOOD: begin
        repeat (klen) q.push_back(text_byte());
        q.push_back(EQ_CHAR);
        repeat (vlen) q.push_back(text_byte());
        q.push_back(BANG_CHAR);
      end
      FR_NO_EQ: begin
        repeat (klen + vlen) q.push_back(text_byte());
        q.push_back(BANG_CHAR);
      end
      FR_MULTI_EQ: begin
        repeat ($urandom_range(2, 4)) begin
          repeat (klen) q.push_back(text_byte());
          q.push_back(EQ_CHAR);
        end
        repeat (vlen) q.push_back(text_byte());
        q.push_back(BANG_CHAR);
      end
      FR_EQ_FIRST: begin
        q.push_back(EQ_CHAR);
        repeat (klen + vlen) q.push_back(text_byte());
        q.push_back(BANG_CHAR);
      end
      FR_EQ_LAST: begin
        repeat (klen + vlen) q.push_back(text_byte());
        q.push_back(EQ_CHAR);
        q.push_back(BANG_CHAR);
      end
      FR_SHORT: begin
        repeat ($urandom_range(0, 2)) q.push_back($urandom_range(1) ? EQ_CHAR : text_byte());
        q.push_back(BANG_CHAR);
      end
      FR_OVERFLOW: begin
        // The last of these bytes finds the buffer full; the rest fall outside a frame
        repeat (DEPTH_DEFAULT - 1) q.push_back(text_byte());
        repeat ($urandom_range(0, 3)) q.push_back(text_byte());
      end
      default: begin
        // Good frame that fills the buffer exactly
        klen = $urandom_range(1, DEPTH_DEFAULT - 5);
        repeat (klen) q.push_back(text_byte());
        q.push_back(EQ_CHAR);
        repeat (DEPTH_DEFAULT - 4 - klen) q.push_back(text_byte());
        q.push_back(BANG_CHAR);
      end
    endcase
    send_bytes(q);
  endtask

  // Mostly well-formed frames, the rest broken in each way the format check knows
  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 58) return FR_GOOD;
    if (r < 66) return FR_NO_EQ;
    if (r < 72) return FR_MULTI_EQ;
    if (r < 78) return FR_EQ_FIRST;
    if (r < 84) return FR_EQ_LAST;
    if (r < 90) return FR_SHORT;
    if (r < 94) return FR_OVERFLOW;
    return FR_LONGEST;
  endfunction

  // Read back a few bytes, sometimes poke a byte at the held frame, then mostly release it
  task automatic after_frame();
    repeat ($urandom_range(3))
      send_item(CMD_READ, BYTE_W'($urandom),
                INDEX_W'($urandom_range(1) ? $urandom_range(9) : $urandom_range(63)));
    if ($urandom_range(4) == 0) send_item(CMD_BYTE, BYTE_W'($urandom), INDEX_W'($urandom));
    if ($urandom_range(9) != 0)
      send_item(CMD_RELEASE, BYTE_W'($urandom), INDEX_W'($urandom));
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
    int stop_at;
    stop_at       = items_sent + quota;
    src_idle_pct  = idle_pct;
    snk_stall_pct <= stall_pct;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(CMD_W'($urandom), BYTE_W'($urandom), INDEX_W'($urandom));
      end else begin
        send_frame(pick_kind());
        after_frame();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: stray byte, empty read, unused command, idle release, early close
    send_item(CMD_BYTE, 8'hFF, 6'h3F);
    send_item(CMD_READ, 8'h00, 6'h00);
    send_item(CMD_UNUSED, BANG_CHAR, 6'h00);
    send_item(CMD_RELEASE, 8'h00, 6'h00);
    send_item(CMD_BYTE, BANG_CHAR, 6'h00);
    send_item(CMD_BYTE, BANG_CHAR, 6'h00);
    // Shortest good frame with extreme text bytes, then a byte while it is held
    send_item(CMD_BYTE, BANG_CHAR, 6'h00);
    send_item(CMD_BYTE, 8'h00, 6'h00);
    send_item(CMD_BYTE, EQ_CHAR, 6'h00);
    send_item(CMD_BYTE, 8'hFF, 6'h00);
    send_item(CMD_BYTE, BANG_CHAR, 6'h00);
    send_item(CMD_BYTE, BANG_CHAR, 6'h00);
    // Reads inside and beyond the held frame, then release
    send_item(CMD_READ, 8'h00, 6'h00);
    send_item(CMD_READ, 8'h00, 6'h04);
    send_item(CMD_READ, 8'hFF, 6'h3F);
    send_item(CMD_RELEASE, 8'h00, 6'h00);
    // Separator right after the opening delimiter
    send_item(CMD_BYTE, BANG_CHAR, 6'h00);
    send_item(CMD_BYTE, EQ_CHAR, 6'h00);
    send_item(CMD_BYTE, 8'h61, 6'h00);
    send_item(CMD_BYTE, 8'h62, 6'h00);
    send_item(CMD_BYTE, BANG_CHAR, 6'h00);

    // Both buffer extremes early, then the idling mixes; the first one opens with a hold-off
    send_frame(FR_OVERFLOW);
    after_frame();
    send_frame(FR_LONGEST);
    after_frame();
    hold_requests <= hold_requests + 1;
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(69, 0, PHASE_ITEMS);
    run_phase(0, 69, PHASE_ITEMS);
    run_phase(35, 35, ITEM_TARGET - items_sent);
    s_tvalid <= 1'b0;

    // Drain the outstanding results, then let the output settle
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands and %0d checked results over four idling mixes",
             items_sent, results_checked);
    $display("  with one long output hold-off; frames held %0d, rejected %0d, dropped %0d.",
             frames_accepted, frames_rejected, frames_dropped);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
